[rtl/jsg_pkg.sv]
// shared widths, register map and codes for the joystick send gate
package jsg_pkg;

  localparam int unsigned POS_W    = 12;  // sent position and register width
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned IVAL_W   = 16;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned OUT_W    = POS_W + POS_W + TIME_W + COUNT_W;

  typedef enum logic [2:0] {
    REG_DEADZONE_X        = 3'd0,
    REG_DEADZONE_Y        = 3'd1,
    REG_CENTER_LEVEL      = 3'd2,
    REG_REPEAT_INTERVAL   = 3'd3,
    REG_CONSECUTIVE_LIMIT = 3'd4
  } reg_idx_t;

  localparam logic [POS_W-1:0]   DEADZONE_RST = POS_W'(100);
  localparam logic [POS_W-1:0]   CENTER_RST   = POS_W'(2048);
  localparam logic [IVAL_W-1:0]  INTERVAL_RST = IVAL_W'(100);
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = LIMIT_W'(3);

endpackage

[rtl/joystick_send_gate_unit.sv]
// joystick send gate: decides per sample whether a transmit request goes out
//
// usage:
//   s_* carries joystick samples (x, y, millisecond time), m_* carries
//   transmit requests (x, y, time, running send number). a sample that
//   causes no send produces nothing on m_*.
//   the apb port holds five registers at byte addresses 0,4,..,16; write
//   them only while no sample is in flight.
// flow:
//   a sample is taken into an input register, evaluated combinationally and
//   its request (if any) lands in the result register. one sample per
//   cycle is sustained while no request waits or m_tready is high; the
//   evaluation of each sample sees the reference left by the one before it.
// reset (rst, synchronous): both registers empty, not seeded, reference
//   and send counter zero, registers at their default values.
// stall: while m_tready is low and a request waits, the sample in the
//   input register holds and s_tready drops; the input side keeps taking
//   samples whenever the input register is empty or can drain this cycle.
// note: any move beyond a deadzone sends and clears the move counters, so
//   they never carry a value past one sample; the quick-send rule only
//   fires by itself when consecutive_limit is zero.
module joystick_send_gate_unit #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: sample_x, sample_y, time_ms, zero pad
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [((2*SAMPLE_BITS+32+7)/8)*8-1:0] s_tdata,
  // m_tdata: sent_x, sent_y, sent_time_ms, send_number
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [jsg_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jsg_pkg::APB_AW-1:0]    paddr,
  input  logic [jsg_pkg::APB_DW-1:0]    pwdata,
  output logic [jsg_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned DW = (SAMPLE_BITS > jsg_pkg::POS_W) ? SAMPLE_BITS : jsg_pkg::POS_W;
  localparam int unsigned TW = jsg_pkg::TIME_W;

  // configuration registers
  logic [jsg_pkg::POS_W-1:0]   deadzone_x;
  logic [jsg_pkg::POS_W-1:0]   deadzone_y;
  logic [jsg_pkg::POS_W-1:0]   center_level;
  logic [jsg_pkg::IVAL_W-1:0]  repeat_interval;
  logic [jsg_pkg::LIMIT_W-1:0] consecutive_limit;

  // tracking state
  logic                        seeded;
  logic [SAMPLE_BITS-1:0]      ref_x;
  logic [SAMPLE_BITS-1:0]      ref_y;
  logic [TW-1:0]               last_send_time;
  logic [jsg_pkg::COUNT_W-1:0] packets_sent;

  // input register
  logic                        in_valid;
  logic [SAMPLE_BITS-1:0]      in_x;
  logic [SAMPLE_BITS-1:0]      in_y;
  logic [TW-1:0]               in_time;

  logic                        proc_fire;
  logic                        do_send;
  logic                        cfg_write;
  jsg_pkg::reg_idx_t           cfg_idx;

  function automatic logic [DW-1:0] absdiff(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // ---------------------------------------------------------------- apb
  assign pready    = 1'b1;
  assign cfg_idx   = jsg_pkg::reg_idx_t'(paddr[jsg_pkg::APB_AW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_x        <= jsg_pkg::DEADZONE_RST;
      deadzone_y        <= jsg_pkg::DEADZONE_RST;
      center_level      <= jsg_pkg::CENTER_RST;
      repeat_interval   <= jsg_pkg::INTERVAL_RST;
      consecutive_limit <= jsg_pkg::LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        jsg_pkg::REG_DEADZONE_X:        deadzone_x <= pwdata[jsg_pkg::POS_W-1:0];
        jsg_pkg::REG_DEADZONE_Y:        deadzone_y <= pwdata[jsg_pkg::POS_W-1:0];
        jsg_pkg::REG_CENTER_LEVEL:      center_level <= pwdata[jsg_pkg::POS_W-1:0];
        jsg_pkg::REG_REPEAT_INTERVAL:   repeat_interval <= pwdata[jsg_pkg::IVAL_W-1:0];
        jsg_pkg::REG_CONSECUTIVE_LIMIT: consecutive_limit <= pwdata[jsg_pkg::LIMIT_W-1:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      jsg_pkg::REG_DEADZONE_X:        prdata = jsg_pkg::APB_DW'(deadzone_x);
      jsg_pkg::REG_DEADZONE_Y:        prdata = jsg_pkg::APB_DW'(deadzone_y);
      jsg_pkg::REG_CENTER_LEVEL:      prdata = jsg_pkg::APB_DW'(center_level);
      jsg_pkg::REG_REPEAT_INTERVAL:   prdata = jsg_pkg::APB_DW'(repeat_interval);
      jsg_pkg::REG_CONSECUTIVE_LIMIT: prdata = jsg_pkg::APB_DW'(consecutive_limit);
      default:                        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  // the input register drains whenever the result register is free or emptying
  assign proc_fire = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_x    <= s_tdata[SAMPLE_BITS-1:0];
      in_y    <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      in_time <= s_tdata[2*SAMPLE_BITS+TW-1:2*SAMPLE_BITS];
    end
  end

  // ---------------------------------------------------------------- decision
  logic [DW-1:0] xw, yw, rxw, ryw, cw;
  logic [TW-1:0] eff_last;
  logic [TW-1:0] elapsed;
  logic          moved_x, moved_y, outside, repeat_due, dir_change, quick;

  always_comb begin
    xw  = DW'(in_x);
    yw  = DW'(in_y);
    // the first sample seeds the reference before it is judged
    rxw = seeded ? DW'(ref_x) : xw;
    ryw = seeded ? DW'(ref_y) : yw;
    eff_last = seeded ? last_send_time : in_time;
    cw  = DW'(center_level);

    moved_x    = absdiff(xw, rxw) > DW'(deadzone_x);
    moved_y    = absdiff(yw, ryw) > DW'(deadzone_y);
    outside    = (absdiff(xw, cw) > DW'(deadzone_x)) ||
                 (absdiff(yw, cw) > DW'(deadzone_y));
    elapsed    = in_time - eff_last;
    repeat_due = outside && (elapsed >= TW'(repeat_interval));
    // y swung across center, far from it on both sides
    dir_change = (absdiff(ryw, cw) > DW'(deadzone_y)) &&
                 (absdiff(yw, cw) > DW'(deadzone_y)) &&
                 ((ryw < cw) != (yw < cw));
    // counters start every sample at zero, so only a zero limit trips alone
    quick      = (consecutive_limit == '0);
    do_send    = quick || repeat_due || moved_x || moved_y || dir_change;
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded         <= 1'b0;
      ref_x          <= '0;
      ref_y          <= '0;
      last_send_time <= '0;
      packets_sent   <= '0;
    end else if (proc_fire) begin
      seeded <= 1'b1;
      if (do_send || !seeded) begin
        ref_x          <= in_x;
        ref_y          <= in_y;
        last_send_time <= in_time;
      end
      if (do_send) begin
        packets_sent <= packets_sent + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc_fire) begin
      m_tvalid <= do_send;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && do_send) begin
      m_tdata <= {packets_sent + 1'b1, in_time,
                  yw[jsg_pkg::POS_W-1:0], xw[jsg_pkg::POS_W-1:0]};
    end
  end

endmodule

[rtl/jsg_checker.sv]
// port-level checker for the joystick send gate, bound to the top level
module jsg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [jsg_pkg::OUT_W-1:0]     m_tdata,
  input logic                          psel,
  input logic                          pready
);

  localparam int unsigned NUM_LSB = jsg_pkg::OUT_W - jsg_pkg::COUNT_W;

  logic [jsg_pkg::COUNT_W-1:0] last_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_num <= '0;
    end else if (m_tvalid && m_tready) begin
      last_num <= m_tdata[jsg_pkg::OUT_W-1:NUM_LSB];
    end
  end

  // send numbers run up by one per delivered request
  a_send_number_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |-> m_tdata[jsg_pkg::OUT_W-1:NUM_LSB] == last_num + 1'b1)
    else $error("send number out of sequence");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled request changed");

  // with no request waiting the input side can never be blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("request present after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    psel |-> pready)
    else $error("apb wait state inserted");

endmodule

bind joystick_send_gate_unit jsg_checker u_jsg_checker (.*);
